// ===== hdl/cdn_pkg.sv =====
// Shared types, constants and calendar tables for the date-to-day-number block.
// No dependencies; imported by every module under hdl/.
package cdn_pkg;

  localparam int unsigned DayW   = 6;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 16;
  localparam int unsigned CountW = 25;
  localparam int unsigned MagW   = 15;
  localparam int unsigned ProdW  = 24;
  localparam int unsigned CentW  = 9;

  localparam logic signed [YearW-1:0] ReformYear  = 16'sd1582;
  localparam logic signed [YearW-1:0] MinYear     = -16'sd45;
  localparam logic signed [YearW-1:0] CentYear17  = 16'sd1700;
  localparam logic signed [YearW-1:0] CentYear18  = 16'sd1800;
  localparam logic [16:0]             EpochYear   = 17'd1900;
  localparam logic [ProdW-1:0]        DaysPerYear = 24'd365;
  localparam logic [27:0]             RecipHund   = 28'd5243;
  localparam int unsigned             RecipShift  = 19;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthSep = 4'd9;
  localparam logic [MonthW-1:0] MonthOct = 4'd10;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  localparam logic [DayW-1:0] GapFirstDay = 6'd5;
  localparam logic [DayW-1:0] GapLastDay  = 6'd14;

  typedef struct packed {
    logic [DayW-1:0]          day_of_month;
    logic [MonthW-1:0]        month_number;
    logic signed [YearW-1:0]  year_number;
  } in_item_t;

  typedef struct packed {
    logic signed [CountW-1:0] day_count;
    logic                     date_valid;
  } out_item_t;

  // classified request passed from front to back
  typedef struct packed {
    logic                pre_ok;     // all checks except month length
    logic                after_epoch; // year >= 1900
    logic                mod4_zero;
    logic                cent_noleap; // 1700 or 1800
    logic                shift10;    // Julian-side ten-day shift applies
    logic                bc_year;
    logic [DayW-1:0]     day;
    logic [MonthW-1:0]   month;
    logic [MagW-1:0]     mag;        // |year - 1900|
    logic [ProdW-1:0]    yr_days;    // whole years times 365
    logic [CentW-1:0]    hund;       // centuries in mag, capped at 2 before 1900
  } front_item_t;

  function automatic logic [4:0] month_len(input logic [MonthW-1:0] m);
    logic [4:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

  // days before the month in a common year
  function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] days_after(input logic [MonthW-1:0] m);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd366;
      4'd2:    r = 9'd335;
      4'd3:    r = 9'd307;
      4'd4:    r = 9'd276;
      4'd5:    r = 9'd246;
      4'd6:    r = 9'd215;
      4'd7:    r = 9'd185;
      4'd8:    r = 9'd154;
      4'd9:    r = 9'd123;
      4'd10:   r = 9'd93;
      4'd11:   r = 9'd62;
      4'd12:   r = 9'd32;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/calendar_date_to_day_number.sv =====
// Top level: calendar date to signed day count from 1 Jan 1900.
// Depends on cdn_pkg, cdn_front, cdn_queue, cdn_back.
//
//   channel  handshake               payload
//   in       in_valid_i/in_ready_o   in_item_i  (day, month, signed year)
//   out      out_valid_o/out_ready_i out_item_o (day count, valid flag)
//
// One request per cycle sustained while out_ready_i is high; path: queue, then output register.
// in_ready_o drops only when the two-entry queue is full.
// Reset clears queue pointers and the output valid; no clearing pass.
// A stalled output backs up into the queue, then into the input.
module calendar_date_to_day_number (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cdn_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cdn_pkg::out_item_t out_item_o
);
  import cdn_pkg::*;

  front_item_t cls;
  front_item_t head;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;

  assign in_ready_o = !q_full;

  cdn_front u_front (
    .item_i (in_item_i),
    .cls_o  (cls)
  );

  cdn_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i && !q_full),
    .push_item_i (cls),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  cdn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (head),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== hdl/cdn_front.sv =====
// Front end: range checks, year classification and the two constant multiplies.
// Depends on cdn_pkg.
module cdn_front (
  input  cdn_pkg::in_item_t    item_i,
  output cdn_pkg::front_item_t cls_o
);
  import cdn_pkg::*;

  logic signed [YearW-1:0] y;
  logic [DayW-1:0]   d;
  logic [MonthW-1:0] m;
  logic [16:0]       diff_full;
  logic [16:0]       ndiff_full;
  logic              after_epoch;
  logic [MagW-1:0]   mag;
  logic [MagW-1:0]   yr_opnd;
  logic [27:0]       hund_prod;
  logic              gap;

  assign y = item_i.year_number;
  assign d = item_i.day_of_month;
  assign m = item_i.month_number;

  assign diff_full   = {y[YearW-1], y} - EpochYear;
  assign ndiff_full  = EpochYear - {y[YearW-1], y};
  assign after_epoch = ~diff_full[16];
  assign mag         = after_epoch ? diff_full[MagW-1:0] : {4'd0, ndiff_full[10:0]};
  assign yr_opnd     = after_epoch ? mag : mag - 15'd1;
  assign hund_prod   = 28'(mag) * RecipHund;

  assign gap = (y == ReformYear) && (m == MonthOct) && (d >= GapFirstDay) && (d <= GapLastDay);

  always_comb begin
    cls_o.pre_ok = (m >= MonthJan) && (m <= MonthDec) && (d != '0) && (y != '0)
                   && (y >= MinYear) && !gap;
    cls_o.after_epoch = after_epoch;
    cls_o.mod4_zero   = (y[1:0] == 2'b00);
    cls_o.cent_noleap = (y == CentYear17) || (y == CentYear18);
    cls_o.shift10     = (y < ReformYear) ||
                        ((y == ReformYear) && ((m <= MonthSep) ||
                         ((m == MonthOct) && (d < GapFirstDay))));
    cls_o.bc_year     = y[YearW-1];
    cls_o.day         = d;
    cls_o.month       = m;
    cls_o.mag         = mag;
    cls_o.yr_days     = ProdW'(yr_opnd) * DaysPerYear;
    if (after_epoch) begin
      cls_o.hund = hund_prod[RecipShift +: CentW];
    end else if (mag >= 15'd200) begin
      cls_o.hund = 9'd2;
    end else if (mag >= 15'd100) begin
      cls_o.hund = 9'd1;
    end else begin
      cls_o.hund = '0;
    end
  end

endmodule

// ===== hdl/cdn_queue.sv =====
// Two-entry queue of classified requests between front and back.
// Depends on cdn_pkg.
module cdn_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  cdn_pkg::front_item_t push_item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output cdn_pkg::front_item_t head_o
);
  import cdn_pkg::*;

  front_item_t slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== hdl/cdn_back.sv =====
// Back end: leap decision, month-length check, day sum and output register.
// Depends on cdn_pkg.
module cdn_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  cdn_pkg::front_item_t item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cdn_pkg::out_item_t   out_item_o
);
  import cdn_pkg::*;

  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;
  logic [15:0]     hund_x100;
  logic            rem_zero;
  logic            leap;
  logic [4:0]      mlen;
  logic            ok;
  logic [CentW-1:0] q400;
  logic [MagW-1:0] nleap;
  logic [CountW-1:0] base, adj, tot;

  assign pop_o = valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    hund_x100 = {1'b0, item_i.hund, 6'd0} + {2'b0, item_i.hund, 5'd0}
              + {5'b0, item_i.hund, 2'd0};
    rem_zero  = ({1'b0, item_i.mag} == hund_x100);
    leap = item_i.mod4_zero && !item_i.cent_noleap &&
           !(item_i.after_epoch && rem_zero && (item_i.hund[1:0] != 2'b01));
    mlen = (item_i.month == MonthFeb) ? (leap ? 5'd29 : 5'd28) : month_len(item_i.month);
    ok   = item_i.pre_ok && ({1'b0, item_i.day} <= {2'b0, mlen});

    if (item_i.after_epoch && (item_i.hund != '0)) begin
      q400 = 9'd1 + ((item_i.hund - 9'd1) >> 2);
    end else begin
      q400 = '0;
    end
    nleap = (item_i.mag >> 2) - MagW'(item_i.hund) + MagW'(q400);
    base  = CountW'(item_i.yr_days) + CountW'(nleap);

    if (item_i.after_epoch) begin
      adj = CountW'(days_before(item_i.month)) + CountW'(item_i.day) - 25'd1
          - CountW'(leap && (item_i.month <= MonthFeb));
    end else begin
      adj = CountW'(days_after(item_i.month)) - CountW'(item_i.day)
          - (item_i.shift10 ? 25'd10 : 25'd0)
          - (item_i.bc_year ? 25'd366 : 25'd0)
          - CountW'(leap && (item_i.month > MonthFeb));
    end
    tot = base + adj;

    out_d.date_valid = ok;
    if (!ok) begin
      out_d.day_count = '0;
    end else if (item_i.after_epoch) begin
      out_d.day_count = signed'(tot);
    end else begin
      out_d.day_count = signed'(-tot);
    end

    out_valid_d = pop_o || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
